/* rtl/tsgc_pkg.sv */
// ----------------------------------------------------------------------------
// tsgc_pkg
// Shared types and constants of the touch swipe gesture classifier.
// ----------------------------------------------------------------------------
package tsgc_pkg;

    // Field widths
    localparam int RAW_W    = 12;   // raw converter reading, calibration bounds
    localparam int THR_W    = 8;    // thresholds and long press minimum
    localparam int POS_W    = 16;   // signed screen position
    localparam int SIZE_W   = 13;   // screen size, up to 8191
    localparam int CNT_W    = 8;    // saturating class counter
    localparam int RANK_W   = 3;    // first-appearance rank
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Screen size
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    // Divider sizing: quotient bits below the saturation limit
    localparam int QUO_W   = POS_W - 1;
    localparam int PROD_W  = RAW_W + SIZE_W;
    localparam int DSH_W   = RAW_W + QUO_W - 1;
    localparam int SATC_W  = RAW_W + QUO_W;
    localparam int ITER_W  = $clog2(QUO_W);

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Step classes
    localparam int NUM_CLASSES = 6;
    localparam int IDX_W = $clog2(NUM_CLASSES);

    typedef enum logic [IDX_W-1:0] {
        CL_DIAG  = 3'd0,
        CL_RIGHT = 3'd1,
        CL_LEFT  = 3'd2,
        CL_DOWN  = 3'd3,
        CL_UP    = 3'd4,
        CL_STILL = 3'd5
    } t_class;

    // Gesture codes
    typedef enum logic [2:0] {
        G_SHORT = 3'd0,
        G_LONG  = 3'd1,
        G_LEFT  = 3'd2,
        G_RIGHT = 3'd3,
        G_UP    = 3'd4,
        G_DOWN  = 3'd5
    } t_gesture;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MAX_X = 3'd1,
        CFG_MIN_Y = 3'd2,
        CFG_MAX_Y = 3'd3,
        CFG_THR_X = 3'd4,
        CFG_THR_Y = 3'd5,
        CFG_LONG  = 3'd6
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [RAW_W-1:0] RST_MIN_X = 12'd370;
    localparam logic [RAW_W-1:0] RST_MAX_X = 12'd3700;
    localparam logic [RAW_W-1:0] RST_MIN_Y = 12'd470;
    localparam logic [RAW_W-1:0] RST_MAX_Y = 12'd3600;
    localparam logic [THR_W-1:0] RST_THR_X = 8'd10;
    localparam logic [THR_W-1:0] RST_THR_Y = 8'd10;
    localparam logic [THR_W-1:0] RST_LONG  = 8'd8;

    // Top-level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_X,
        S_WAIT_X,
        S_MAP_Y,
        S_WAIT_Y,
        S_STEP,
        S_PICK,
        S_EMIT
    } t_state;

    // Mapping divider sequencer
    typedef enum logic [2:0] {
        D_IDLE,
        D_MUL,
        D_SAT,
        D_ITER,
        D_FIX,
        D_DONE
    } t_div_state;

    // Request to and response from the axis mapping unit
    typedef struct packed {
        logic              start;
        logic [RAW_W-1:0]  raw;
        logic [RAW_W-1:0]  lo;
        logic [RAW_W-1:0]  hi;
        logic [SIZE_W-1:0] size;
    } t_map_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] pos;
    } t_map_rsp;

endpackage

/* rtl/tsgc_map_div.sv */
// ----------------------------------------------------------------------------
// tsgc_map_div
// Axis mapping unit: (raw - lo) * size / (hi - lo), truncated toward zero and
// saturated to 16 bits signed, by one multiply and a restoring divide that
// retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsgc_map_div
    import tsgc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_map_req i_req,
    output t_map_rsp o_rsp
);

    t_div_state r_state, n_state;

    logic              r_zero, n_zero;
    logic              r_neg, n_neg;
    logic [RAW_W-1:0]  r_diff, n_diff;
    logic [RAW_W-1:0]  r_div, n_div;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [DSH_W-1:0]  r_dsh, n_dsh;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic             ge;
    logic [POS_W-1:0] quo_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        r_neg  <= n_neg;
        r_diff <= n_diff;
        r_div  <= n_div;
        r_size <= n_size;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_pos  <= n_pos;
    end

    assign ge      = DSH_W'(r_rem) >= r_dsh;
    assign quo_ext = {1'b0, r_quo};

    always_comb begin
        n_state = r_state;
        n_zero  = r_zero;
        n_neg   = r_neg;
        n_diff  = r_diff;
        n_div   = r_div;
        n_size  = r_size;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_pos   = r_pos;

        unique case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    n_zero  = i_req.hi <= i_req.lo;
                    n_neg   = i_req.raw < i_req.lo;
                    n_diff  = (i_req.raw < i_req.lo) ? (i_req.lo - i_req.raw)
                                                     : (i_req.raw - i_req.lo);
                    n_div   = i_req.hi - i_req.lo;
                    n_size  = i_req.size;
                    n_state = D_MUL;
                end
            end
            D_MUL: begin
                n_rem   = {{SIZE_W{1'b0}}, r_diff} * {{RAW_W{1'b0}}, r_size};
                n_state = D_SAT;
            end
            D_SAT: begin
                // Quotient that does not fit below 2^15 saturates right away
                if (r_zero) begin
                    n_pos   = '0;
                    n_state = D_DONE;
                end else if (SATC_W'(r_rem) >= {r_div, {QUO_W{1'b0}}}) begin
                    n_pos   = r_neg ? POS_MIN : POS_MAX;
                    n_state = D_DONE;
                end else begin
                    n_dsh   = {r_div, {(QUO_W-1){1'b0}}};
                    n_quo   = '0;
                    n_cnt   = ITER_W'(QUO_W - 1);
                    n_state = D_ITER;
                end
            end
            D_ITER: begin
                if (ge) begin
                    n_rem = r_rem - PROD_W'(r_dsh);
                end
                n_quo = {r_quo[QUO_W-2:0], ge};
                n_dsh = r_dsh >> 1;
                if (r_cnt == '0) begin
                    n_state = D_FIX;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            D_FIX: begin
                n_pos   = r_neg ? (POS_W'(0) - quo_ext) : quo_ext;
                n_state = D_DONE;
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.pos  = r_pos;

endmodule

/* rtl/touch_swipe_gesture_classifier_core.sv */
// ----------------------------------------------------------------------------
// touch_swipe_gesture_classifier_core
// Maps each touch sample to screen coordinates, classes the step from the
// previous sample (diagonal, right, left, down, up, still) and counts each
// class; an end-of-touch transaction picks the most frequent class, earliest
// first on a tie, and emits at most one gesture code before clearing the
// touch state. Both axes go through one shared multiply and one-bit-a-cycle
// divide unit, X first and then Y; an axis whose result saturates or whose
// calibration range is empty skips the divide steps. An end of touch scans
// the six class counters one per cycle. The input is not ready while an item
// is being worked. A gesture waits in an output register; a further end of
// touch holds in its last cycle until that register is free.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_classifier_core
    import tsgc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // Input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [RAW_W-1:0]     i_raw_x,
    input  logic [RAW_W-1:0]     i_raw_y,
    // Output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_gesture
);

    // Configuration registers
    logic [RAW_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [THR_W-1:0] r_thr_x, r_thr_y, r_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= RST_MIN_X;
            r_max_x <= RST_MAX_X;
            r_min_y <= RST_MIN_Y;
            r_max_y <= RST_MAX_Y;
            r_thr_x <= RST_THR_X;
            r_thr_y <= RST_THR_Y;
            r_long  <= RST_LONG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_X: r_min_x <= i_cfg_data;
                CFG_MAX_X: r_max_x <= i_cfg_data;
                CFG_MIN_Y: r_min_y <= i_cfg_data;
                CFG_MAX_Y: r_max_y <= i_cfg_data;
                CFG_THR_X: r_thr_x <= i_cfg_data[THR_W-1:0];
                CFG_THR_Y: r_thr_y <= i_cfg_data[THR_W-1:0];
                CFG_LONG:  r_long  <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and touch state
    t_state r_state, n_state;

    logic [RAW_W-1:0] r_raw_x, r_raw_y;
    logic [POS_W-1:0] r_cur_x, r_cur_y;
    logic [POS_W-1:0] r_prev_x, r_prev_y;
    logic             r_have_prev;

    logic [CNT_W-1:0]       r_count [NUM_CLASSES];
    logic [RANK_W-1:0]      r_rank  [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_seen;
    logic [RANK_W-1:0]      r_next_rank;

    logic [IDX_W-1:0]  r_idx;
    logic              r_best_valid;
    t_class            r_best;
    logic [CNT_W-1:0]  r_best_cnt;
    logic [RANK_W-1:0] r_best_rank;

    logic     r_out_valid;
    t_gesture r_gesture;

    t_map_req map_req;
    t_map_rsp map_rsp;

    tsgc_map_div u_map_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    // Step classification
    logic signed [POS_W:0] dx, dy;
    logic [POS_W:0]        ax, ay;
    logic                  mov_x, mov_y;
    t_class                step_class;

    assign dx = $signed({r_cur_x[POS_W-1], r_cur_x}) - $signed({r_prev_x[POS_W-1], r_prev_x});
    assign dy = $signed({r_cur_y[POS_W-1], r_cur_y}) - $signed({r_prev_y[POS_W-1], r_prev_y});
    assign ax = dx[POS_W] ? (~dx + 1'b1) : dx;
    assign ay = dy[POS_W] ? (~dy + 1'b1) : dy;
    assign mov_x = ax > (POS_W+1)'(r_thr_x);
    assign mov_y = ay > (POS_W+1)'(r_thr_y);

    always_comb begin
        if (mov_x && mov_y) begin
            step_class = CL_DIAG;
        end else if (mov_x) begin
            step_class = dx[POS_W] ? CL_LEFT : CL_RIGHT;
        end else if (mov_y) begin
            step_class = dy[POS_W] ? CL_UP : CL_DOWN;
        end else begin
            step_class = CL_STILL;
        end
    end

    // One read port on the class tables, shared by counting and the scan
    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  cnt_sel;
    logic [RANK_W-1:0] rank_sel;
    logic              seen_sel;
    logic              take;

    assign sel      = (r_state == S_PICK) ? r_idx : step_class;
    assign cnt_sel  = r_count[sel];
    assign rank_sel = r_rank[sel];
    assign seen_sel = r_seen[sel];
    assign take     = seen_sel && (!r_best_valid || (cnt_sel > r_best_cnt) ||
                      ((cnt_sel == r_best_cnt) && (rank_sel < r_best_rank)));

    logic     in_acc;
    logic     do_count;
    logic     do_clear;
    logic     load_out;
    logic     no_result;
    t_gesture gesture;

    assign in_acc    = i_in_valid && o_in_ready;
    assign no_result = !r_best_valid || (r_best == CL_DIAG);

    always_comb begin
        unique case (r_best)
            CL_RIGHT: gesture = G_RIGHT;
            CL_LEFT:  gesture = G_LEFT;
            CL_DOWN:  gesture = G_DOWN;
            CL_UP:    gesture = G_UP;
            default:  gesture = (r_best_cnt < r_long) ? G_SHORT : G_LONG;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        do_count   = 1'b0;
        do_clear   = 1'b0;
        load_out   = 1'b0;
        map_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = i_cmd ? S_PICK : S_MAP_X;
                end
            end
            S_MAP_X: begin
                map_req.start = 1'b1;
                map_req.raw   = r_raw_x;
                map_req.lo    = r_min_x;
                map_req.hi    = r_max_x;
                map_req.size  = SIZE_W'(SCREEN_WIDTH);
                n_state       = S_WAIT_X;
            end
            S_WAIT_X: begin
                if (map_rsp.done) begin
                    n_state = S_MAP_Y;
                end
            end
            S_MAP_Y: begin
                map_req.start = 1'b1;
                map_req.raw   = r_raw_y;
                map_req.lo    = r_min_y;
                map_req.hi    = r_max_y;
                map_req.size  = SIZE_W'(SCREEN_HEIGHT);
                n_state       = S_WAIT_Y;
            end
            S_WAIT_Y: begin
                if (map_rsp.done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                do_count = r_have_prev;
                n_state  = S_IDLE;
            end
            S_PICK: begin
                if (r_idx == IDX_W'(NUM_CLASSES - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold while an earlier gesture still waits to be taken
                if (no_result) begin
                    do_clear = 1'b1;
                    n_state  = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    do_clear = 1'b1;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
        end
        if (r_state == S_WAIT_X && map_rsp.done) begin
            r_cur_x <= map_rsp.pos;
        end
        if (r_state == S_WAIT_Y && map_rsp.done) begin
            r_cur_y <= map_rsp.pos;
        end
        if (in_acc) begin
            r_idx        <= '0;
            r_best_valid <= 1'b0;
        end else if (r_state == S_PICK) begin
            r_idx <= r_idx + 1'b1;
            if (take) begin
                r_best_valid <= 1'b1;
                r_best       <= t_class'(r_idx);
                r_best_cnt   <= cnt_sel;
                r_best_rank  <= rank_sel;
            end
        end
        if (load_out) begin
            r_gesture <= gesture;
        end
    end

    // Touch state: cleared by reset and by every end of touch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_clear) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_seen      <= '0;
            r_next_rank <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_count[i] <= '0;
                r_rank[i]  <= '0;
            end
        end else if (r_state == S_STEP) begin
            r_prev_x    <= r_cur_x;
            r_prev_y    <= r_cur_y;
            r_have_prev <= 1'b1;
            if (do_count) begin
                if (!seen_sel) begin
                    // First occurrence counts zero and takes the next rank
                    r_seen[sel]  <= 1'b1;
                    r_count[sel] <= '0;
                    r_rank[sel]  <= r_next_rank;
                    r_next_rank  <= r_next_rank + 1'b1;
                end else if (cnt_sel != COUNT_MAX) begin
                    r_count[sel] <= cnt_sel + 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_gesture;

`ifndef SYNTH
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("gesture raised outside the emit step");

    a_clear_after_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_IDLE) |=>
            (!r_have_prev && r_seen == '0 && r_next_rank == '0))
        else $error("touch state not cleared after end of touch");

    a_gesture_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gesture <= G_DOWN)
        else $error("gesture code out of range");
`endif

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the touch swipe gesture classifier core. A
// tracker object mirrors the calibration mapping, step classing and winner
// selection, queues the gesture each end of touch should produce, and checks
// every gesture transaction in order. Stimulus is a short directed set
// followed by random swipes, noise and broken touches under several register
// settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsgc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int PHASE_ITEMS    = 160;
    localparam int FULL_COUNT_LEN = 270;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam logic [RAW_W-1:0] RAW_TOP = 12'd4095;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_END    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    class gesture_tracker;
        logic [RAW_W-1:0] min_x, max_x, min_y, max_y;
        logic [THR_W-1:0] thr_x, thr_y, long_min;
        bit               have_prev;
        int               prev_x, prev_y;
        int               class_cnt  [NUM_CLASSES];
        bit               class_seen [NUM_CLASSES];
        int               class_rank [NUM_CLASSES];
        int               next_rank;
        t_gesture         expected_gestures [$];
        int               failures;

        function void clear_touch();
            have_prev = 1'b0;
            prev_x    = 0;
            prev_y    = 0;
            next_rank = 0;
            foreach (class_cnt[i]) begin
                class_cnt[i]  = 0;
                class_seen[i] = 1'b0;
                class_rank[i] = 0;
            end
        endfunction

        function void load_reset_values();
            min_x    = RST_MIN_X;
            max_x    = RST_MAX_X;
            min_y    = RST_MIN_Y;
            max_y    = RST_MAX_Y;
            thr_x    = RST_THR_X;
            thr_y    = RST_THR_Y;
            long_min = RST_LONG;
            failures = 0;
            clear_touch();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_MIN_X: min_x    = data[RAW_W-1:0];
                CFG_MAX_X: max_x    = data[RAW_W-1:0];
                CFG_MIN_Y: min_y    = data[RAW_W-1:0];
                CFG_MAX_Y: max_y    = data[RAW_W-1:0];
                CFG_THR_X: thr_x    = data[THR_W-1:0];
                CFG_THR_Y: thr_y    = data[THR_W-1:0];
                CFG_LONG:  long_min = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int map_axis(logic [RAW_W-1:0] raw, lo, hi, int size);
            longint num, q;
            if (hi <= lo) return 0;
            num = (longint'(raw) - longint'(lo)) * size;
            q   = num / (longint'(hi) - longint'(lo));
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return int'(q);
        endfunction

        function void note_item(logic c, logic [RAW_W-1:0] rx, ry);
            int       x, y, dx, dy, best, i;
            t_class   step;
            t_gesture g_exp;
            if (c == CMD_SAMPLE) begin
                x = map_axis(rx, min_x, max_x, SCREEN_WIDTH);
                y = map_axis(ry, min_y, max_y, SCREEN_HEIGHT);
                if (have_prev) begin
                    dx = x - prev_x;
                    dy = y - prev_y;
                    if ((dx < 0 ? -dx : dx) <= int'(thr_x)) dx = 0;
                    if ((dy < 0 ? -dy : dy) <= int'(thr_y)) dy = 0;
                    if (dx != 0 && dy != 0) step = CL_DIAG;
                    else if (dx > 0)        step = CL_RIGHT;
                    else if (dx < 0)        step = CL_LEFT;
                    else if (dy > 0)        step = CL_DOWN;
                    else if (dy < 0)        step = CL_UP;
                    else                    step = CL_STILL;
                    // first occurrence opens the class at zero and takes a rank
                    if (!class_seen[step]) begin
                        class_seen[step] = 1'b1;
                        class_cnt[step]  = 0;
                        class_rank[step] = next_rank;
                        next_rank        = (next_rank + 1) % 8;
                    end else if (class_cnt[step] < 255) begin
                        class_cnt[step]++;
                    end
                end
                prev_x    = x;
                prev_y    = y;
                have_prev = 1'b1;
                return;
            end
            best = -1;
            for (i = 0; i < NUM_CLASSES; i++) begin
                if (!class_seen[i]) continue;
                if (best < 0 || class_cnt[i] > class_cnt[best] ||
                    (class_cnt[i] == class_cnt[best] && class_rank[i] < class_rank[best]))
                    best = i;
            end
            if (best >= 0 && best != CL_DIAG) begin
                case (t_class'(best))
                    CL_RIGHT: g_exp = G_RIGHT;
                    CL_LEFT:  g_exp = G_LEFT;
                    CL_DOWN:  g_exp = G_DOWN;
                    CL_UP:    g_exp = G_UP;
                    default: begin
                        if (class_cnt[best] < int'(long_min))
                            g_exp = G_SHORT;
                        else
                            g_exp = G_LONG;
                    end
                endcase
                expected_gestures = {expected_gestures, g_exp};
            end
            clear_touch();
        endfunction

        function void check_gesture(logic [2:0] g);
            t_gesture want;
            if (expected_gestures.size() == 0) begin
                $error("gesture: no result expected, actual %0d", g);
                failures++;
                return;
            end
            want = expected_gestures.pop_front();
            if (g !== want) begin
                $error("gesture: expected %0d, actual %0d", want, g);
                failures++;
            end
        endfunction

        function int pending();
            return expected_gestures.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 cmd;
    logic [RAW_W-1:0]     raw_x;
    logic [RAW_W-1:0]     raw_y;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           gesture;

    gesture_tracker tracker = new;

    int burst_left = 0;
    int items_sent = 0;
    int stall_left = 0;
    int mode_left  = 0;
    bit stall_mode = 1'b1;

    touch_swipe_gesture_classifier_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_cmd       (cmd),
        .i_raw_x     (raw_x),
        .i_raw_y     (raw_y),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_gesture   (gesture)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: random stalls, switched on and off in long stretches
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready = 1'b0;
        end else if (stall_left != 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else begin
            out_ready = 1'b1;
            if (stall_mode && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 40);
        end
        if (mode_left == 0) begin
            stall_mode = !stall_mode;
            mode_left  = $urandom_range(200, 2000);
        end else begin
            mode_left--;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) tracker.check_gesture(gesture);
    end

    function automatic logic [RAW_W-1:0] clamp_raw(int v);
        if (v < 0) return '0;
        if (v > int'(RAW_TOP)) return RAW_TOP;
        return RAW_W'(v);
    endfunction

    task automatic send_item(input logic c, input logic [RAW_W-1:0] rx, ry);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        in_valid = 1'b1;
        cmd      = c;
        raw_x    = rx;
        raw_y    = ry;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_item(c, rx, ry);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Wait for the block to drain, then load a full register set
    task automatic program_settings(input int mnx, mxx, mny, mxy, tx, ty, lp);
        in_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_UNUSED, CFG_DAT_W'($urandom));
        write_reg(CFG_MIN_X, CFG_DAT_W'(mnx));
        write_reg(CFG_MAX_X, CFG_DAT_W'(mxx));
        write_reg(CFG_MIN_Y, CFG_DAT_W'(mny));
        write_reg(CFG_MAX_Y, CFG_DAT_W'(mxy));
        // upper data bits must be dropped by the 8-bit registers
        write_reg(CFG_THR_X, {4'($urandom), 8'(tx)});
        write_reg(CFG_THR_Y, {4'($urandom), 8'(ty)});
        write_reg(CFG_LONG,  {4'($urandom), 8'(lp)});
        cfg_we = 1'b0;
    endtask

    task automatic choose_settings(input int phase);
        int a, b;
        case (phase % 6)
            0: program_settings(0, RAW_TOP, 0, RAW_TOP, 0, 0, 0);
            1: program_settings(RST_MIN_X, RST_MAX_X, RST_MIN_Y, RST_MAX_Y, 255, 255, 255);
            2: begin
                // empty calibration ranges pin every position at zero
                a = $urandom_range(0, RAW_TOP);
                b = $urandom_range(0, RAW_TOP);
                program_settings(a, a, b, $urandom_range(0, b), $urandom_range(0, 20),
                                 $urandom_range(0, 20), $urandom_range(0, 12));
            end
            3: program_settings(2000, 2001, int'(RAW_TOP) - 1, RAW_TOP, $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 12));
            default: begin
                a = $urandom_range(0, 2000);
                b = $urandom_range(0, 2000);
                program_settings(a, $urandom_range(a + 1, RAW_TOP), b,
                                 $urandom_range(b + 1, RAW_TOP), $urandom_range(0, 40),
                                 $urandom_range(0, 40), $urandom_range(0, 12));
            end
        endcase
    endtask

    task automatic random_touch();
        int     kind, n, mag, x, y, step_x, step_y;
        t_class dir;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            n   = $urandom_range(2, 12);
            dir = t_class'($urandom_range(0, NUM_CLASSES - 1));
            case ($urandom_range(0, 2))
                0:       mag = $urandom_range(0, 150);
                1:       mag = $urandom_range(150, 800);
                default: mag = $urandom_range(800, 3000);
            endcase
            step_x = 0;
            step_y = 0;
            case (dir)
                CL_RIGHT: step_x = mag;
                CL_LEFT:  step_x = -mag;
                CL_DOWN:  step_y = mag;
                CL_UP:    step_y = -mag;
                CL_DIAG: begin
                    step_x = $urandom_range(0, 1) ? mag : -mag;
                    step_y = $urandom_range(0, 1) ? mag : -mag;
                end
                default: ;
            endcase
            x = (step_x > 0) ? $urandom_range(0, 1200) :
                (step_x < 0) ? $urandom_range(2900, RAW_TOP) : $urandom_range(0, RAW_TOP);
            y = (step_y > 0) ? $urandom_range(0, 1200) :
                (step_y < 0) ? $urandom_range(2900, RAW_TOP) : $urandom_range(0, RAW_TOP);
            repeat (n) begin
                send_item(CMD_SAMPLE, clamp_raw(x), clamp_raw(y));
                x += step_x + int'($urandom_range(0, 40)) - 20;
                y += step_y + int'($urandom_range(0, 40)) - 20;
                // occasional detour to mix classes inside one swipe
                if ($urandom_range(0, 9) == 0) begin
                    x += int'($urandom_range(0, 1200)) - 600;
                    y += int'($urandom_range(0, 1200)) - 600;
                end
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(0, 6))
                send_item(CMD_SAMPLE, RAW_W'($urandom), RAW_W'($urandom));
        end else if ($urandom_range(0, 1) == 1) begin
            send_item(CMD_SAMPLE, RAW_W'($urandom), RAW_W'($urandom));
        end
        send_item(CMD_END, RAW_W'($urandom), RAW_W'($urandom));
    endtask

    initial begin
        int start, phase_end, phase, px, py;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MIN_X;
        cfg_data  = '0;
        in_valid  = 1'b0;
        cmd       = CMD_SAMPLE;
        raw_x     = '0;
        raw_y     = '0;
        tracker.load_reset_values();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed touches under reset calibration
        send_item(CMD_END, '0, '0);
        send_item(CMD_SAMPLE, RAW_TOP, '0);
        send_item(CMD_END, RAW_TOP, RAW_TOP);
        send_item(CMD_SAMPLE, 2000, 2000);
        send_item(CMD_SAMPLE, 2000, 2000);
        send_item(CMD_END, '0, '0);
        send_item(CMD_SAMPLE, 3500, 1000);
        send_item(CMD_SAMPLE, 3000, 1000);
        send_item(CMD_END, '0, '0);
        send_item(CMD_SAMPLE, 2000, 500);
        send_item(CMD_SAMPLE, 2000, 1200);
        send_item(CMD_END, '0, '0);
        send_item(CMD_SAMPLE, 2000, 3500);
        send_item(CMD_SAMPLE, 2000, 2800);
        send_item(CMD_END, '0, '0);
        send_item(CMD_SAMPLE, 500, 500);
        send_item(CMD_SAMPLE, 1500, 1500);
        send_item(CMD_END, '0, '0);
        // right then left at equal counts: the earlier class wins
        send_item(CMD_SAMPLE, 1000, 2000);
        send_item(CMD_SAMPLE, 1600, 2000);
        send_item(CMD_SAMPLE, 1000, 2000);
        send_item(CMD_END, '0, '0);
        send_item(CMD_SAMPLE, '0, '0);
        send_item(CMD_SAMPLE, RAW_TOP, RAW_TOP);
        send_item(CMD_END, '0, '0);

        // Hold one spot long enough to saturate the still counter
        program_settings(RST_MIN_X, RST_MAX_X, RST_MIN_Y, RST_MAX_Y, 10, 10, 255);
        px = $urandom_range(100, 3900);
        py = $urandom_range(100, 3900);
        repeat (FULL_COUNT_LEN)
            send_item(CMD_SAMPLE, clamp_raw(px + int'($urandom_range(0, 8)) - 4),
                      clamp_raw(py + int'($urandom_range(0, 8)) - 4));
        send_item(CMD_END, '0, '0);

        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            choose_settings(phase);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent - start < RANDOM_ITEMS)
                random_touch();
            phase++;
        end

        in_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("touch_swipe_gesture_classifier_core regression: pass");
        else
            $display("touch_swipe_gesture_classifier_core regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("touch_swipe_gesture_classifier_core regression: fail");
        $finish;
    end

endmodule
